[rtl/itpt_pkg.sv]
// ----------------------------------------------------------------------------
// itpt_pkg: shared types and constants of the integer-to-text unit
// Flag bit positions, character codes, digit-serial divider sizing and
// the control structs passed between the top level and its sub-blocks.
// ----------------------------------------------------------------------------
package itpt_pkg;

   // value and digit sizing
   localparam int VALUE_WIDTH       = 64;
   localparam int DIGIT_SLOTS       = 64;
   localparam int DIGIT_WIDTH       = 6;
   localparam int DIGIT_COUNT_WIDTH = $clog2(DIGIT_SLOTS + 1);

   // divider: quotient bits resolved per cycle
   localparam int DIV_BITS   = 8;
   localparam int DIV_STEPS  = VALUE_WIDTH / DIV_BITS;
   localparam int STEP_WIDTH = $clog2(DIV_STEPS);

   // radix limits
   localparam logic [5:0] RADIX_MIN = 6'd2;
   localparam logic [5:0] RADIX_MAX = 6'd36;
   localparam logic [5:0] RADIX_OCT = 6'd8;
   localparam logic [5:0] RADIX_HEX = 6'd16;

   // format flag bit positions
   localparam int ZERO_FILL_POS = 0;
   localparam int SIGNED_POS    = 1;
   localparam int PLUS_POS      = 2;
   localparam int SPACE_POS     = 3;
   localparam int LEFT_POS      = 4;
   localparam int ALT_POS       = 5;
   localparam int UPPER_POS     = 6;

   // ascii codes
   localparam logic [6:0] CHAR_SPACE   = 7'h20;
   localparam logic [6:0] CHAR_PLUS    = 7'h2b;
   localparam logic [6:0] CHAR_MINUS   = 7'h2d;
   localparam logic [6:0] CHAR_ZERO    = 7'h30;
   localparam logic [6:0] CHAR_UPPER_A = 7'h41;
   localparam logic [6:0] CHAR_LOWER_A = 7'h61;
   localparam logic [6:0] CHAR_UPPER_X = 7'h58;
   localparam logic [6:0] CHAR_LOWER_X = 7'h78;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SETUP,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      SIGN_NONE,
      SIGN_MINUS,
      SIGN_PLUS,
      SIGN_SPACE
   } sign_type;

   typedef struct packed {
      logic                   done;
      logic                   more;
      logic [DIGIT_WIDTH-1:0] digit;
   } div_status_type;

   typedef struct packed {
      logic push;
      logic pop;
   } stack_ctl_type;

   // digit value to ascii, 0-9 then letters
   function automatic logic [6:0] digit_to_ascii(input logic [DIGIT_WIDTH-1:0] d,
                                                 input logic upper);
      logic [6:0] base;
      base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
      if (d < 6'd10) begin
         digit_to_ascii = CHAR_ZERO + 7'(d);
      end else begin
         digit_to_ascii = base + 7'(d) - 7'd10;
      end
   endfunction

endpackage

[rtl/itpt_if.sv]
// ----------------------------------------------------------------------------
// itpt_if: request and response channel interfaces
// Valid/ready channels carrying one value to format and one output character.
// ----------------------------------------------------------------------------
interface itpt_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] value_bits;
   logic [5:0]  radix;
   logic [5:0]  field_width;
   logic [5:0]  min_digits;
   logic [6:0]  format_flags;

   modport source (output valid, value_bits, radix, field_width, min_digits, format_flags,
                   input ready);
   modport sink   (input valid, value_bits, radix, field_width, min_digits, format_flags,
                   output ready);
endinterface

interface itpt_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] character;
   logic       last_char;

   modport source (output valid, character, last_char, input ready);
   modport sink   (input valid, character, last_char, output ready);
endinterface

[rtl/itpt_serial_divider.sv]
// ----------------------------------------------------------------------------
// itpt_serial_divider: digit-serial divide by radix
// The quotient rotates through a shift register a byte per cycle while a
// narrow remainder chain resolves eight quotient bits; one digit per pass.
// ----------------------------------------------------------------------------
module itpt_serial_divider (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              load,
   input  logic [itpt_pkg::VALUE_WIDTH-1:0]  load_value,
   input  logic [5:0]                        load_radix,
   output itpt_pkg::div_status_type          status
);

   localparam logic [itpt_pkg::STEP_WIDTH-1:0] StepLast =
      itpt_pkg::STEP_WIDTH'(itpt_pkg::DIV_STEPS - 1);

   logic                                  active_ff, active_in;
   logic [itpt_pkg::STEP_WIDTH-1:0]       step_ff, step_in;
   logic [itpt_pkg::VALUE_WIDTH-1:0]      quot_ff, quot_in;
   logic [itpt_pkg::DIGIT_WIDTH-1:0]      rem_ff, rem_in;
   logic                                  nz_ff, nz_in;
   logic [5:0]                            radix_ff, radix_in;

   logic [itpt_pkg::DIV_BITS-1:0]         qbyte;
   logic [itpt_pkg::DIGIT_WIDTH-1:0]      chain_rem;
   logic                                  last_step;

   // restoring division over the top byte of the rotating quotient
   always_comb begin
      logic [itpt_pkg::DIGIT_WIDTH:0] trial;
      logic [itpt_pkg::DIGIT_WIDTH-1:0] r;
      r     = rem_ff;
      qbyte = '0;
      for (int i = 0; i < itpt_pkg::DIV_BITS; i++) begin
         trial = {r, quot_ff[itpt_pkg::VALUE_WIDTH-1-i]};
         if (trial >= {1'b0, radix_ff}) begin
            trial = trial - {1'b0, radix_ff};
            qbyte[itpt_pkg::DIV_BITS-1-i] = 1'b1;
         end
         r = trial[itpt_pkg::DIGIT_WIDTH-1:0];
      end
      chain_rem = r;
   end

   assign last_step    = active_ff && (step_ff == StepLast);
   assign status.done  = last_step;
   assign status.more  = nz_ff || (qbyte != '0);
   assign status.digit = chain_rem;

   always_comb begin
      active_in = active_ff;
      step_in   = step_ff;
      quot_in   = quot_ff;
      rem_in    = rem_ff;
      nz_in     = nz_ff;
      radix_in  = radix_ff;
      if (load) begin
         active_in = 1'b1;
         step_in   = '0;
         quot_in   = load_value;
         rem_in    = '0;
         nz_in     = 1'b0;
         radix_in  = load_radix;
      end else if (active_ff) begin
         quot_in = {quot_ff[itpt_pkg::VALUE_WIDTH-itpt_pkg::DIV_BITS-1:0], qbyte};
         step_in = step_ff + itpt_pkg::STEP_WIDTH'(1);
         if (last_step) begin
            rem_in    = '0;
            nz_in     = 1'b0;
            active_in = status.more;
         end else begin
            rem_in = chain_rem;
            nz_in  = nz_ff || (qbyte != '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         step_ff   <= '0;
      end else begin
         active_ff <= active_in;
         step_ff   <= step_in;
      end
      quot_ff  <= quot_in;
      rem_ff   <= rem_in;
      nz_ff    <= nz_in;
      radix_ff <= radix_in;
   end

endmodule

[rtl/itpt_digit_stack.sv]
// ----------------------------------------------------------------------------
// itpt_digit_stack: last-in first-out digit store
// Shift-register stack; digits arrive least significant first and leave
// most significant first from the head slot.
// ----------------------------------------------------------------------------
module itpt_digit_stack (
   input  logic                                clock,
   input  itpt_pkg::stack_ctl_type             ctl,
   input  logic [itpt_pkg::DIGIT_WIDTH-1:0]    push_digit,
   output logic [itpt_pkg::DIGIT_WIDTH-1:0]    head_digit
);

   logic [itpt_pkg::DIGIT_WIDTH-1:0] slot_ff [itpt_pkg::DIGIT_SLOTS];
   logic [itpt_pkg::DIGIT_WIDTH-1:0] slot_in [itpt_pkg::DIGIT_SLOTS];

   always_comb begin
      for (int i = 0; i < itpt_pkg::DIGIT_SLOTS; i++) begin
         slot_in[i] = slot_ff[i];
      end
      if (ctl.push) begin
         slot_in[0] = push_digit;
         for (int i = 1; i < itpt_pkg::DIGIT_SLOTS; i++) begin
            slot_in[i] = slot_ff[i-1];
         end
      end else if (ctl.pop) begin
         for (int i = 0; i < itpt_pkg::DIGIT_SLOTS - 1; i++) begin
            slot_in[i] = slot_ff[i+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < itpt_pkg::DIGIT_SLOTS; i++) begin
         slot_ff[i] <= slot_in[i];
      end
   end

   assign head_digit = slot_ff[0];

endmodule

[rtl/integer_to_padded_text_unit.sv]
// ----------------------------------------------------------------------------
// integer_to_padded_text_unit: printf-style integer to ascii formatter
// Converts a 64-bit value to radix digits, then emits sign, prefix, fill,
// digits and padding one character per response transaction.
// ----------------------------------------------------------------------------
//  channel    dir  payload                                          end marker
//  req_chan   in   value_bits, radix, field_width, min_digits,      -
//                  format_flags
//  rsp_chan   out  character                                        last_char
//
//  the divider resolves eight quotient bits per cycle through its remainder
//  chain to form 1..64 digits, the setup state then computes the layout, and
//  emission gives one character per cycle while rsp_chan is not stalled
//  req_chan is ready only in idle; a request with a radix outside 2..36 is
//  accepted and dropped, staying in idle with no response
//  reset is synchronous and clears the sequencer and the output valid
//  a stalled rsp_chan holds the output register and freezes emission
// ----------------------------------------------------------------------------
module integer_to_padded_text_unit #(
   parameter int MAX_FIELD = 48
) (
   input  logic       clock,
   input  logic       reset,
   itpt_req_if.sink   req_chan,
   itpt_rsp_if.source rsp_chan
);

   // widths of layout positions: pad + sign + prefix + digits, with margin
   localparam int CW = $clog2(MAX_FIELD + itpt_pkg::DIGIT_SLOTS + 4);
   localparam int NW = itpt_pkg::DIGIT_COUNT_WIDTH;
   localparam logic [5:0]    MaxFieldSat = 6'(MAX_FIELD);
   localparam logic [CW-1:0] OutLimit    = CW'(MAX_FIELD + 3);

   // sequencer
   itpt_pkg::state_type state_ff, state_in;

   // per-transaction format registers
   logic [5:0]         width_ff, width_in;
   logic [5:0]         prec_ff, prec_in;
   logic               zero_ff, zero_in;
   logic               left_ff, left_in;
   logic               upper_ff, upper_in;
   logic [1:0]         prefix_len_ff, prefix_len_in;
   itpt_pkg::sign_type sign_ff, sign_in;
   logic [NW-1:0]      nd_ff, nd_in;

   // layout boundaries, positions counted from the first character
   logic [CW-1:0] lead_end_ff, lead_end_in;
   logic [CW-1:0] sign_end_ff, sign_end_in;
   logic [CW-1:0] pref_end_ff, pref_end_in;
   logic [CW-1:0] zero_end_ff, zero_end_in;
   logic [CW-1:0] dig_end_ff, dig_end_in;
   logic [CW-1:0] last_idx_ff, last_idx_in;
   logic [CW-1:0] emit_idx_ff, emit_idx_in;

   // output register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [6:0] char_ff, char_in;
   logic       last_ff, last_in;

   // control
   logic                                 accept;
   logic                                 radix_ok;
   logic                                 div_load;
   logic                                 load_out;
   logic                                 in_digits;
   logic [6:0]                           char_sel;
   logic                                 last_sel;
   logic [itpt_pkg::VALUE_WIDTH-1:0]     magnitude;
   itpt_pkg::sign_type                   sign_sel;
   itpt_pkg::div_status_type             div_status;
   itpt_pkg::stack_ctl_type              stack_ctl;
   logic [itpt_pkg::DIGIT_WIDTH-1:0]     head_digit;

   assign accept   = req_chan.valid && req_chan.ready;
   assign radix_ok = (req_chan.radix >= itpt_pkg::RADIX_MIN) &&
                     (req_chan.radix <= itpt_pkg::RADIX_MAX);
   assign req_chan.ready = (state_ff == itpt_pkg::ST_IDLE);

   // sign choice and magnitude, two's complement negate for a negative value
   always_comb begin
      logic [6:0] f;
      f = req_chan.format_flags;
      sign_sel  = itpt_pkg::SIGN_NONE;
      magnitude = req_chan.value_bits;
      if (f[itpt_pkg::SIGNED_POS]) begin
         if (req_chan.value_bits[itpt_pkg::VALUE_WIDTH-1]) begin
            sign_sel  = itpt_pkg::SIGN_MINUS;
            magnitude = '0 - req_chan.value_bits;
         end else if (f[itpt_pkg::PLUS_POS]) begin
            sign_sel = itpt_pkg::SIGN_PLUS;
         end else if (f[itpt_pkg::SPACE_POS]) begin
            sign_sel = itpt_pkg::SIGN_SPACE;
         end
      end
   end

   itpt_serial_divider u_divider (
      .clock      (clock),
      .reset      (reset),
      .load       (div_load),
      .load_value (magnitude),
      .load_radix (req_chan.radix),
      .status     (div_status)
   );

   itpt_digit_stack u_stack (
      .clock      (clock),
      .ctl        (stack_ctl),
      .push_digit (div_status.digit),
      .head_digit (head_digit)
   );

   // character at the current emission position
   always_comb begin
      in_digits = 1'b0;
      char_sel  = itpt_pkg::CHAR_SPACE;
      if (emit_idx_ff < lead_end_ff) begin
         char_sel = itpt_pkg::CHAR_SPACE;
      end else if (emit_idx_ff < sign_end_ff) begin
         unique case (sign_ff)
            itpt_pkg::SIGN_MINUS: char_sel = itpt_pkg::CHAR_MINUS;
            itpt_pkg::SIGN_PLUS:  char_sel = itpt_pkg::CHAR_PLUS;
            itpt_pkg::SIGN_SPACE: char_sel = itpt_pkg::CHAR_SPACE;
            itpt_pkg::SIGN_NONE:  char_sel = itpt_pkg::CHAR_SPACE;
            default:              char_sel = itpt_pkg::CHAR_SPACE;
         endcase
      end else if (emit_idx_ff < pref_end_ff) begin
         // octal prefix is a single zero, hex gets zero then x
         if (emit_idx_ff == sign_end_ff) begin
            char_sel = itpt_pkg::CHAR_ZERO;
         end else begin
            char_sel = upper_ff ? itpt_pkg::CHAR_UPPER_X : itpt_pkg::CHAR_LOWER_X;
         end
      end else if (emit_idx_ff < zero_end_ff) begin
         char_sel = itpt_pkg::CHAR_ZERO;
      end else if (emit_idx_ff < dig_end_ff) begin
         in_digits = 1'b1;
         char_sel  = itpt_pkg::digit_to_ascii(head_digit, upper_ff);
      end
      last_sel = (emit_idx_ff == last_idx_ff);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         itpt_pkg::ST_IDLE: begin
            if (accept && radix_ok) begin
               state_in = itpt_pkg::ST_CONVERT;
            end
         end
         itpt_pkg::ST_CONVERT: begin
            if (div_status.done && !div_status.more) begin
               state_in = itpt_pkg::ST_SETUP;
            end
         end
         itpt_pkg::ST_SETUP: begin
            state_in = itpt_pkg::ST_EMIT;
         end
         itpt_pkg::ST_EMIT: begin
            if (load_out && last_sel) begin
               state_in = itpt_pkg::ST_IDLE;
            end
         end
         default: state_in = itpt_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      div_load       = 1'b0;
      load_out       = 1'b0;
      stack_ctl.push = 1'b0;
      stack_ctl.pop  = 1'b0;
      unique case (state_ff)
         itpt_pkg::ST_IDLE:    div_load = accept && radix_ok;
         itpt_pkg::ST_CONVERT: stack_ctl.push = div_status.done;
         itpt_pkg::ST_SETUP:   ;
         itpt_pkg::ST_EMIT: begin
            load_out      = !rsp_valid_ff || rsp_chan.ready;
            stack_ctl.pop = load_out && in_digits;
         end
         default: ;
      endcase
   end

   // format capture, digit count and layout
   always_comb begin
      logic [6:0]    f;
      logic          sign_len;
      logic [NW-1:0] prec_eff;
      logic [CW-1:0] used;
      logic [CW-1:0] pad;
      logic [CW-1:0] lead;
      logic [CW-1:0] fill;
      logic [CW-1:0] tail;
      logic [CW-1:0] total;

      f             = req_chan.format_flags;
      total         = '0;
      width_in      = width_ff;
      prec_in       = prec_ff;
      zero_in       = zero_ff;
      left_in       = left_ff;
      upper_in      = upper_ff;
      prefix_len_in = prefix_len_ff;
      sign_in       = sign_ff;
      nd_in         = nd_ff;
      lead_end_in   = lead_end_ff;
      sign_end_in   = sign_end_ff;
      pref_end_in   = pref_end_ff;
      zero_end_in   = zero_end_ff;
      dig_end_in    = dig_end_ff;
      last_idx_in   = last_idx_ff;
      emit_idx_in   = emit_idx_ff;

      if (div_load) begin
         width_in = (req_chan.field_width > MaxFieldSat) ? MaxFieldSat : req_chan.field_width;
         prec_in  = (req_chan.min_digits > MaxFieldSat) ? MaxFieldSat : req_chan.min_digits;
         left_in  = f[itpt_pkg::LEFT_POS];
         // left justify cancels zero fill
         zero_in  = f[itpt_pkg::ZERO_FILL_POS] && !f[itpt_pkg::LEFT_POS];
         upper_in = f[itpt_pkg::UPPER_POS];
         sign_in  = sign_sel;
         prefix_len_in = 2'd0;
         if (f[itpt_pkg::ALT_POS]) begin
            if (req_chan.radix == itpt_pkg::RADIX_HEX) begin
               prefix_len_in = 2'd2;
            end else if (req_chan.radix == itpt_pkg::RADIX_OCT) begin
               prefix_len_in = 2'd1;
            end
         end
         nd_in = '0;
      end

      if (stack_ctl.push) begin
         nd_in = nd_ff + NW'(1);
      end

      // layout arithmetic, only latched in the setup cycle
      sign_len = (sign_ff != itpt_pkg::SIGN_NONE);
      prec_eff = (nd_ff > NW'(prec_ff)) ? nd_ff : NW'(prec_ff);
      used     = CW'(sign_len) + CW'(prefix_len_ff) + CW'(prec_eff);
      pad      = (CW'(width_ff) > used) ? CW'(width_ff) - used : '0;
      lead     = (!zero_ff && !left_ff) ? pad : '0;
      fill     = zero_ff ? pad : '0;
      tail     = left_ff ? pad : '0;
      if (state_ff == itpt_pkg::ST_SETUP) begin
         lead_end_in = lead;
         sign_end_in = lead + CW'(sign_len);
         pref_end_in = lead + CW'(sign_len) + CW'(prefix_len_ff);
         zero_end_in = lead + CW'(sign_len) + CW'(prefix_len_ff) + fill
                       + CW'(prec_eff - nd_ff);
         dig_end_in  = lead + CW'(sign_len) + CW'(prefix_len_ff) + fill + CW'(prec_eff);
         total       = dig_end_in + tail;
         // text beyond the output limit is dropped
         last_idx_in = (total > OutLimit) ? OutLimit - CW'(1) : total - CW'(1);
         emit_idx_in = '0;
      end

      if (load_out) begin
         emit_idx_in = emit_idx_ff + CW'(1);
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         char_in      = char_sel;
         last_in      = last_sel;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= itpt_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      width_ff      <= width_in;
      prec_ff       <= prec_in;
      zero_ff       <= zero_in;
      left_ff       <= left_in;
      upper_ff      <= upper_in;
      prefix_len_ff <= prefix_len_in;
      sign_ff       <= sign_in;
      nd_ff         <= nd_in;
      lead_end_ff   <= lead_end_in;
      sign_end_ff   <= sign_end_in;
      pref_end_ff   <= pref_end_in;
      zero_end_ff   <= zero_end_in;
      dig_end_ff    <= dig_end_in;
      last_idx_ff   <= last_idx_in;
      emit_idx_ff   <= emit_idx_in;
      char_ff       <= char_in;
      last_ff       <= last_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.character = char_ff;
   assign rsp_chan.last_char = last_ff;

   // divider only finishes digits while the sequencer is converting
   assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> state_ff == itpt_pkg::ST_CONVERT)
      else $error("divider digit outside conversion");

   // a value always has between one and sixty-four digits once emitting
   assert property (@(posedge clock) disable iff (reset)
      state_ff == itpt_pkg::ST_EMIT |->
         nd_ff != '0 && nd_ff <= NW'(itpt_pkg::DIGIT_SLOTS))
      else $error("digit count out of range during emission");

   // emission never runs past the final character
   assert property (@(posedge clock) disable iff (reset)
      state_ff == itpt_pkg::ST_EMIT |-> emit_idx_ff <= last_idx_ff)
      else $error("emission index beyond last character");

   // loading the final character ends the transaction with it on the output
   assert property (@(posedge clock) disable iff (reset)
      load_out && last_sel |=> state_ff == itpt_pkg::ST_IDLE && rsp_valid_ff && last_ff)
      else $error("final character did not close the transaction");

endmodule

[tb/integer_to_padded_text_unit_tb.sv]
// ----------------------------------------------------------------------------
// integer_to_padded_text_unit_tb: self-checking bench for the integer-to-text unit
// Directed corner cases, then randomised values, radices, widths and flags.
// A local formatter predicts the character stream of every accepted request
// and a monitor checks each response transaction against it in order.
// ----------------------------------------------------------------------------
module integer_to_padded_text_unit_tb;

   // field cap of the unit and the longest text it will emit
   localparam int FIELD_CAP  = 48;
   localparam int TEXT_LIMIT = FIELD_CAP + 3;

   // stimulus shaping
   localparam int IDLE_PERCENT = 18;
   localparam int RANDOM_ITEMS = 406;   // on top of the directed requests
   localparam int STEADY_FROM  = 200;   // window of requests with no idling
   localparam int STEADY_TO    = 290;

   // end of run: worst case is 64 binary digits, plus layout and a full text;
   // the watchdog allows several times that between transactions
   localparam int TAIL_CYCLES = 600;
   localparam int STALL_LIMIT = 4000;

   // format flag masks
   localparam logic [6:0] FMT_ZERO   = 7'(1 << itpt_pkg::ZERO_FILL_POS);
   localparam logic [6:0] FMT_SIGNED = 7'(1 << itpt_pkg::SIGNED_POS);
   localparam logic [6:0] FMT_PLUS   = 7'(1 << itpt_pkg::PLUS_POS);
   localparam logic [6:0] FMT_SPACE  = 7'(1 << itpt_pkg::SPACE_POS);
   localparam logic [6:0] FMT_LEFT   = 7'(1 << itpt_pkg::LEFT_POS);
   localparam logic [6:0] FMT_ALT    = 7'(1 << itpt_pkg::ALT_POS);
   localparam logic [6:0] FMT_UPPER  = 7'(1 << itpt_pkg::UPPER_POS);
   localparam logic [6:0] FMT_ALL    = 7'h7f;
   localparam logic [6:0] FMT_NONE   = 7'h00;

   localparam string LOWER_DIGITS = "0123456789abcdefghijklmnopqrstuvwxyz";
   localparam string UPPER_DIGITS = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";
   localparam int    X_POSITION   = 33;

   typedef struct packed {
      logic [63:0] value_bits;
      logic [5:0]  radix;
      logic [5:0]  field_width;
      logic [5:0]  min_digits;
      logic [6:0]  format_flags;
      logic        hold_for_drain;   // sender waits for all text before this one
   } text_request_type;

   typedef struct packed {
      logic [6:0] character;
      logic       last_char;
   } text_char_type;

   logic clock = 1'b0;
   logic reset;

   itpt_req_if req_if ();
   itpt_rsp_if rsp_if ();

   integer_to_padded_text_unit #(
      .MAX_FIELD(FIELD_CAP)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   text_request_type pending_requests[$];
   text_char_type    expected_text[$];
   int               requests_sent = 0;
   int               quiet_cycles = 0;
   int               failures = 0;
   logic             steady_phase;

   // no idling on either side while this window of requests goes through
   assign steady_phase = (requests_sent >= STEADY_FROM) && (requests_sent < STEADY_TO);

   always #10 clock = ~clock;

   // ------------------------------------------------------------------------
   // formatter: works out the characters a request should produce and
   // appends them to the expected text
   // ------------------------------------------------------------------------
   function automatic void format_expected(input text_request_type r);
      logic [63:0]   mag;
      logic [6:0]    flags;
      logic [6:0]    sign_char;
      logic [6:0]    digs[64];
      logic [6:0]    text[$];
      text_char_type c;
      bit            has_sign;
      string         digit_set;
      int            width;
      int            prec;
      int            nd;
      int            k;
      int            emit;

      // out-of-range radix: nothing at all
      if (r.radix < itpt_pkg::RADIX_MIN || r.radix > itpt_pkg::RADIX_MAX) begin
         return;
      end
      width = (r.field_width > FIELD_CAP) ? FIELD_CAP : int'(r.field_width);
      prec  = (r.min_digits > FIELD_CAP) ? FIELD_CAP : int'(r.min_digits);
      flags = r.format_flags;
      // left justification overrides zero fill
      if (flags[itpt_pkg::LEFT_POS]) begin
         flags[itpt_pkg::ZERO_FILL_POS] = 1'b0;
      end
      digit_set = flags[itpt_pkg::UPPER_POS] ? UPPER_DIGITS : LOWER_DIGITS;
      mag       = r.value_bits;
      has_sign  = 1'b0;
      sign_char = itpt_pkg::CHAR_SPACE;

      if (flags[itpt_pkg::SIGNED_POS]) begin
         if (mag[63]) begin
            // most negative value wraps to its own magnitude, exact unsigned
            sign_char = itpt_pkg::CHAR_MINUS;
            mag       = 64'd0 - mag;
            has_sign  = 1'b1;
         end else if (flags[itpt_pkg::PLUS_POS]) begin
            sign_char = itpt_pkg::CHAR_PLUS;
            has_sign  = 1'b1;
         end else if (flags[itpt_pkg::SPACE_POS]) begin
            sign_char = itpt_pkg::CHAR_SPACE;
            has_sign  = 1'b1;
         end
      end
      if (has_sign) begin
         width--;
      end
      if (flags[itpt_pkg::ALT_POS]) begin
         if (r.radix == itpt_pkg::RADIX_HEX) begin
            width -= 2;
         end else if (r.radix == itpt_pkg::RADIX_OCT) begin
            width -= 1;
         end
      end

      // digits, least significant first; zero always gives one digit
      nd = 0;
      if (mag == 64'd0) begin
         digs[0] = itpt_pkg::CHAR_ZERO;
         nd      = 1;
      end else begin
         while (mag != 64'd0) begin
            digs[nd] = 7'(digit_set[int'(mag % r.radix)]);
            mag      = mag / r.radix;
            nd++;
         end
      end
      if (nd > prec) begin
         prec = nd;
      end
      width -= prec;

      if (!flags[itpt_pkg::ZERO_FILL_POS] && !flags[itpt_pkg::LEFT_POS]) begin
         for (; width > 0; width--) text.push_back(itpt_pkg::CHAR_SPACE);
      end
      if (has_sign) begin
         text.push_back(sign_char);
      end
      if (flags[itpt_pkg::ALT_POS]) begin
         if (r.radix == itpt_pkg::RADIX_OCT) begin
            text.push_back(itpt_pkg::CHAR_ZERO);
         end else if (r.radix == itpt_pkg::RADIX_HEX) begin
            text.push_back(itpt_pkg::CHAR_ZERO);
            text.push_back(7'(digit_set[X_POSITION]));
         end
      end
      if (!flags[itpt_pkg::LEFT_POS]) begin
         for (; width > 0; width--) begin
            text.push_back(flags[itpt_pkg::ZERO_FILL_POS] ? itpt_pkg::CHAR_ZERO
                                                          : itpt_pkg::CHAR_SPACE);
         end
      end
      for (k = nd; k < prec; k++) text.push_back(itpt_pkg::CHAR_ZERO);
      for (k = nd - 1; k >= 0; k--) text.push_back(digs[k]);
      for (; width > 0; width--) text.push_back(itpt_pkg::CHAR_SPACE);

      // overlong text is cut short, the last one sent carries the marker
      emit = (text.size() < TEXT_LIMIT) ? text.size() : TEXT_LIMIT;
      for (k = 0; k < emit; k++) begin
         c.character = text[k];
         c.last_char = (k == emit - 1);
         expected_text.push_back(c);
      end
   endfunction

   function automatic void queue_request(input logic [63:0] value, input int radix,
                                         input int field_width, input int min_digits,
                                         input logic [6:0] flags, input bit hold = 1'b0);
      text_request_type r;
      r.value_bits     = value;
      r.radix          = 6'(radix);
      r.field_width    = 6'(field_width);
      r.min_digits     = 6'(min_digits);
      r.format_flags   = flags;
      r.hold_for_drain = hold;
      pending_requests.push_back(r);
   endfunction

   // mostly short fields, some up to the cap, a few beyond it
   function automatic int random_size();
      int roll;
      roll = $urandom_range(99);
      if (roll < 75) begin
         return $urandom_range(20, 0);
      end else if (roll < 93) begin
         return $urandom_range(48, 21);
      end
      return $urandom_range(63, 49);
   endfunction

   // common radices weighted up, a few outside the legal range
   function automatic int random_radix();
      int roll;
      roll = $urandom_range(99);
      if (roll < 8) begin
         return $urandom_range(1) ? $urandom_range(63, 37) : $urandom_range(1, 0);
      end else if (roll < 40) begin
         case ($urandom_range(3))
            0:       return 2;
            1:       return int'(itpt_pkg::RADIX_OCT);
            2:       return 10;
            default: return int'(itpt_pkg::RADIX_HEX);
         endcase
      end
      return $urandom_range(36, 2);
   endfunction

   function automatic logic [63:0] random_value();
      case ($urandom_range(7))
         0:       return 64'd0;
         1:       return 64'($urandom_range(999, 1));
         3:       return 64'd0 - 64'($urandom_range(999, 1));
         4:       return {$urandom, $urandom} >> $urandom_range(60, 1);
         5: begin
            case ($urandom_range(3))
               0:       return 64'h8000_0000_0000_0000;
               1:       return 64'h7fff_ffff_ffff_ffff;
               2:       return 64'hffff_ffff_ffff_ffff;
               default: return 64'd1;
            endcase
         end
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // request driver: presents queued requests, predicts each accepted one
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : request_driver
      text_request_type taken;
      text_request_type next_req;
      bit               send;
      if (reset) begin
         req_if.valid        <= 1'b0;
         req_if.value_bits   <= '0;
         req_if.radix        <= '0;
         req_if.field_width  <= '0;
         req_if.min_digits   <= '0;
         req_if.format_flags <= '0;
         requests_sent       <= 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            taken.value_bits     = req_if.value_bits;
            taken.radix          = req_if.radix;
            taken.field_width    = req_if.field_width;
            taken.min_digits     = req_if.min_digits;
            taken.format_flags   = req_if.format_flags;
            taken.hold_for_drain = 1'b0;
            format_expected(taken);
            requests_sent <= requests_sent + 1;
         end
         // bus is free after this edge: offer the next request or idle
         if (!req_if.valid || req_if.ready) begin
            send = (pending_requests.size() != 0) &&
                   (steady_phase || ($urandom_range(99) >= IDLE_PERCENT));
            // a held request waits until every character so far is back
            if (send && pending_requests[0].hold_for_drain && expected_text.size() != 0) begin
               send = 1'b0;
            end
            if (send) begin
               next_req = pending_requests.pop_front();
               req_if.valid        <= 1'b1;
               req_if.value_bits   <= next_req.value_bits;
               req_if.radix        <= next_req.radix;
               req_if.field_width  <= next_req.field_width;
               req_if.min_digits   <= next_req.min_digits;
               req_if.format_flags <= next_req.format_flags;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // response monitor: checks each character transaction against the oldest
   // expected one, and stalls the output at random
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : response_monitor
      text_char_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_text.size() == 0) begin
               $display("%0t: unexpected character, expected none, actual %h last %b",
                        $time, rsp_if.character, rsp_if.last_char);
               failures++;
            end else begin
               want = expected_text.pop_front();
               if (rsp_if.character !== want.character) begin
                  $display("%0t: character mismatch, expected %h, actual %h",
                           $time, want.character, rsp_if.character);
                  failures++;
               end
               if (rsp_if.last_char !== want.last_char) begin
                  $display("%0t: last_char mismatch, expected %b, actual %b",
                           $time, want.last_char, rsp_if.last_char);
                  failures++;
               end
            end
         end
         rsp_if.ready <= steady_phase || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // watchdog: cycles since the last transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // stimulus list, reset and end of run
   // ------------------------------------------------------------------------
   initial begin : run_control
      int radix;
      int n;
      int end_errors;

      reset      = 1'b1;
      end_errors = 0;

      // zero prints a single digit, with or without a sign, or pads to a minimum digit count
      queue_request(64'd0, 10, 0, 0, FMT_NONE);
      queue_request(64'd0, 10, 0, 0, FMT_SIGNED | FMT_PLUS);
      queue_request(64'd0, 10, 0, 4, FMT_NONE);
      // all ones unsigned: 64 binary digits cut to the text limit, and base 36 upper case
      queue_request(64'hffff_ffff_ffff_ffff, 2, 0, 0, FMT_NONE);
      queue_request(64'hffff_ffff_ffff_ffff, 36, 0, 0, FMT_UPPER);
      // most negative and most positive signed values
      queue_request(64'h8000_0000_0000_0000, 10, 0, 0, FMT_SIGNED);
      queue_request(64'h7fff_ffff_ffff_ffff, 10, 0, 0, FMT_SIGNED | FMT_PLUS);
      // minus one as signed, hex prefix upper case
      queue_request(64'hffff_ffff_ffff_ffff, 16, 0, 0, FMT_SIGNED | FMT_ALT | FMT_UPPER);
      // zero fill lands after the prefix, then the alternate form in octal and decimal and a space sign
      queue_request(64'hdead_beef, 16, 12, 0, FMT_ALT | FMT_ZERO);
      queue_request(64'd8, 8, 6, 0, FMT_ALT);
      queue_request(64'd8, 10, 6, 0, FMT_ALT);
      queue_request(64'd77, 10, 5, 0, FMT_SIGNED | FMT_SPACE);
      // left justify cancels zero fill
      queue_request(64'd42, 10, 10, 0, FMT_SIGNED | FMT_PLUS | FMT_LEFT | FMT_ZERO);
      // width and digit count beyond the cap saturate, then mixed widths, flags and radices
      queue_request(64'd5, 10, 63, 0, FMT_NONE);
      queue_request(64'hffff_ffff_ffff_fff0, 16, 63, 63, FMT_SIGNED | FMT_ALT);
      queue_request(64'd7, 10, 0, 5, FMT_NONE);
      queue_request(64'h123, 16, 20, 3, FMT_ALL);
      queue_request(64'd35, 36, 0, 0, FMT_NONE);
      queue_request(64'h8000_0000_0000_0000, 2, 48, 0, FMT_SIGNED | FMT_LEFT);
      // radices outside 2..36 give no text
      queue_request(64'd99, 0, 8, 0, FMT_NONE);
      queue_request(64'd99, 1, 8, 0, FMT_NONE);
      queue_request(64'd99, 37, 8, 0, FMT_NONE);
      queue_request(64'hffff_ffff_ffff_ffff, 63, 63, 63, FMT_ALL);
      // sender holds until the directed text has all come back
      queue_request(64'd12345, 10, 8, 6, FMT_ZERO, 1'b1);

      // random part
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         radix = random_radix();
         queue_request(random_value(), radix, random_size(), random_size(),
                       7'($urandom_range(127)), (n % 100) == 50);
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while ((pending_requests.size() != 0 || req_if.valid || expected_text.size() != 0) &&
             quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
      end
      // let any stray character show before closing
      for (n = 0; n < TAIL_CYCLES && quiet_cycles < STALL_LIMIT; n++) begin
         @(posedge clock);
      end

      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: watchdog expired after %0d cycles with no transaction",
                  $time, quiet_cycles);
         end_errors++;
      end
      if (expected_text.size() != 0) begin
         $display("%0t: %0d expected characters never arrived", $time, expected_text.size());
         end_errors++;
      end
      if (failures == 0 && end_errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/itpt_pkg.sv
rtl/itpt_if.sv
rtl/itpt_serial_divider.sv
rtl/itpt_digit_stack.sv
rtl/integer_to_padded_text_unit.sv
tb/integer_to_padded_text_unit_tb.sv
